>>> hdl/sbbf_pkg.sv
// ----------------------------------------------------------------------------
// sbbf_pkg
// Shared types and constants for the split-block Bloom filter.
// ----------------------------------------------------------------------------
`default_nettype none

package sbbf_pkg;

    // Block geometry
    localparam int WORDS_PER_BLOCK = 8;
    localparam int WORD_W          = 32;
    localparam int CFG_W           = 4;
    localparam int WIDX_W          = 13;
    localparam int HASH_W          = 64;
    localparam int SALT_SHIFT      = 27;

    typedef logic [WORDS_PER_BLOCK-1:0][WORD_W-1:0] block_t;

    // Per-word salt multipliers
    localparam logic [WORD_W-1:0] SALT [WORDS_PER_BLOCK] = '{
        32'h47b6137b, 32'h44974d91, 32'h8824ad5b, 32'ha2b7289d,
        32'h705495c7, 32'h2df1424b, 32'h9efc4947, 32'h5c6bfb31
    };

    // Request modes
    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_QUERY  = 2'd1,
        MODE_LOAD   = 2'd2,
        MODE_READ   = 2'd3
    } mode_t;

    // Controller states
    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_FETCH,
        S_UPDATE
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic clear_step;
        logic take_item;
        logic rd_block;
        logic commit;
    } sbbf_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic clear_done;
    } sbbf_stat_t;

endpackage

`default_nettype wire

>>> hdl/sbbf_ifs.sv
// ----------------------------------------------------------------------------
// sbbf_ifs
// Request, response and configuration channels of the Bloom filter.
// ----------------------------------------------------------------------------
`default_nettype none

interface sbbf_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [63:0] hash_value;
    logic [12:0] word_index;
    logic [31:0] word_data;

    modport source (output valid, output mode, output hash_value,
                    output word_index, output word_data, input ready);
    modport sink   (input valid, input mode, input hash_value,
                    input word_index, input word_data, output ready);
endinterface

interface sbbf_rsp_if;
    logic        valid;
    logic        ready;
    logic        maybe_present;
    logic [31:0] read_word;

    modport source (output valid, output maybe_present, output read_word, input ready);
    modport sink   (input valid, input maybe_present, input read_word, output ready);
endinterface

interface sbbf_cfg_if;
    logic       valid;
    logic       ready;
    logic [3:0] block_count_log2;

    modport source (output valid, output block_count_log2, input ready);
    modport sink   (input valid, input block_count_log2, output ready);
endinterface

`default_nettype wire

>>> hdl/sbbf_ram.sv
// ----------------------------------------------------------------------------
// sbbf_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module sbbf_ram #(
    parameter int WIDTH = 256,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output      logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> hdl/sbbf_ctrl.sv
// ----------------------------------------------------------------------------
// sbbf_ctrl
// Sequencer: clear sweep, request intake, block fetch and update.
// ----------------------------------------------------------------------------
`default_nettype none

module sbbf_ctrl import sbbf_pkg::*; (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       req_valid,
    output      logic       req_ready,
    output      logic       rsp_valid,
    input  wire logic       rsp_ready,
    input  wire sbbf_stat_t stat,
    output      sbbf_cmd_t  cmd
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    // State and response-valid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        req_ready      = 1'b0;
        if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (stat.clear_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.take_item = 1'b1;
                    state_next    = S_FETCH;
                end
            end
            S_FETCH:
            begin
                cmd.rd_block = 1'b1;
                state_next   = S_UPDATE;
            end
            S_UPDATE:
            begin
                // wait for a free response slot before writing back
                if (!out_valid_reg || rsp_ready)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
        endcase
    end

    assign rsp_valid = out_valid_reg;

endmodule

`default_nettype wire

>>> hdl/sbbf_dp.sv
// ----------------------------------------------------------------------------
// sbbf_dp
// Datapath: request registers, salt mask, block store, response register.
// ----------------------------------------------------------------------------
`default_nettype none

module sbbf_dp import sbbf_pkg::*; #(
    parameter int MAX_BLOCKS = 1024,
    localparam int BW        = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1,
    localparam int KMAX      = $clog2(MAX_BLOCKS + 1) - 1,
    localparam int STORE_WORDS = MAX_BLOCKS * WORDS_PER_BLOCK
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire sbbf_cmd_t         cmd,
    output      sbbf_stat_t        stat,
    input  wire logic              cfg_we,
    input  wire logic [CFG_W-1:0]  cfg_data,
    input  wire logic [1:0]        req_mode,
    input  wire logic [HASH_W-1:0] req_hash,
    input  wire logic [WIDX_W-1:0] req_widx,
    input  wire logic [WORD_W-1:0] req_wdata,
    output      logic              rsp_present,
    output      logic [WORD_W-1:0] rsp_word
);

    logic [CFG_W-1:0]  bcl_reg;
    logic [BW-1:0]     clr_cnt_reg;
    mode_t             mode_reg;
    logic [HASH_W-1:0] hash_reg;
    logic [WIDX_W-1:0] widx_reg;
    logic [WORD_W-1:0] wdata_reg;
    block_t            mask_reg, mask_next;
    logic [BW-1:0]     blk_reg, blk_next;
    logic              present_reg, present_next;
    logic [WORD_W-1:0] rword_reg, rword_next;

    logic [4:0]        k_eff;
    logic [31:0]       hmask;
    logic [31:0]       hblk32;
    logic [31:0]       wblk32;
    logic              widx_ok;
    logic [2:0]        wsel;
    block_t            rd_blk;
    block_t            new_blk;
    logic              wr_ok;
    logic              ram_we;
    logic [BW-1:0]     ram_waddr;
    block_t            ram_wdata;

    // Config register and clear sweep counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bcl_reg     <= '0;
            clr_cnt_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                bcl_reg <= cfg_data;
            end
            if (cmd.clear_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + BW'(1);
            end
        end
    end

    assign stat.clear_done = (clr_cnt_reg == BW'(MAX_BLOCKS - 1));

    // Request capture
    always_ff @(posedge clk)
    begin
        if (cmd.take_item)
        begin
            mode_reg  <= mode_t'(req_mode);
            hash_reg  <= req_hash;
            widx_reg  <= req_widx;
            wdata_reg <= req_wdata;
        end
    end

    // Block address: hash block masked to the saturated block count, or word address
    assign k_eff   = (5'(bcl_reg) > 5'(KMAX)) ? 5'(KMAX) : 5'(bcl_reg);
    assign hmask   = (32'h1 << k_eff) - 32'h1;
    assign hblk32  = hash_reg[63:32] & hmask;
    assign wblk32  = 32'(widx_reg[WIDX_W-1:3]);
    assign widx_ok = (32'(widx_reg) < 32'(STORE_WORDS));
    assign wsel    = widx_reg[2:0];

    always_comb
    begin
        if (mode_reg == MODE_INSERT || mode_reg == MODE_QUERY)
        begin
            blk_next = hblk32[BW-1:0];
        end
        else
        begin
            blk_next = wblk32[BW-1:0];
        end
    end

    // Salted bit mask, one bit per word
    always_comb
    begin
        logic [WORD_W-1:0] prod;
        for (int i = 0; i < WORDS_PER_BLOCK; i++)
        begin
            prod         = hash_reg[31:0] * SALT[i];
            mask_next[i] = 32'h1 << prod[WORD_W-1:SALT_SHIFT];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_block)
        begin
            mask_reg <= mask_next;
            blk_reg  <= blk_next;
        end
    end

    // Block store
    sbbf_ram #(
        .WIDTH ($bits(block_t)),
        .DEPTH (MAX_BLOCKS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.rd_block),
        .raddr (blk_next),
        .rdata (rd_blk)
    );

    // Update and response
    always_comb
    begin
        new_blk      = rd_blk;
        wr_ok        = 1'b0;
        present_next = 1'b0;
        rword_next   = '0;
        case (mode_reg)
            MODE_INSERT:
            begin
                new_blk = rd_blk | mask_reg;
                wr_ok   = 1'b1;
            end
            MODE_QUERY:
            begin
                present_next = 1'b1;
                for (int i = 0; i < WORDS_PER_BLOCK; i++)
                begin
                    if ((rd_blk[i] & mask_reg[i]) == '0)
                    begin
                        present_next = 1'b0;
                    end
                end
            end
            MODE_LOAD:
            begin
                new_blk[wsel] = wdata_reg;
                wr_ok         = widx_ok;
            end
            default:
            begin
                if (widx_ok)
                begin
                    rword_next = rd_blk[wsel];
                end
            end
        endcase
    end

    assign ram_we    = cmd.clear_step | (cmd.commit & wr_ok);
    assign ram_waddr = cmd.clear_step ? clr_cnt_reg : blk_reg;
    assign ram_wdata = cmd.clear_step ? block_t'('0) : new_blk;

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            present_reg <= present_next;
            rword_reg   <= rword_next;
        end
    end

    assign rsp_present = present_reg;
    assign rsp_word    = rword_reg;

endmodule

`default_nettype wire

>>> hdl/split_block_bloom_filter.sv
// ----------------------------------------------------------------------------
// split_block_bloom_filter
// Split-block Bloom filter, 256-bit blocks of eight 32-bit words.
// ----------------------------------------------------------------------------
//  channel | dir | handshake   | payload
//  req     | in  | valid/ready | mode, hash_value, word_index, word_data
//  rsp     | out | valid/ready | maybe_present, read_word
//  cfg     | in  | valid/ready | block_count_log2 (ready always high)
//
//  Each request passes through intake, block read from the store RAM,
//  then mask check / read-modify-write and response load.
//  The single-port-per-direction block RAM sets that order; no new request is taken until it ends.
//  After reset a clear sweep zeroes the store, with req.ready low.
//  A response not yet taken holds the update step, and with it the intake of
//  the next request: req.ready stays low until the response slot frees.
// ----------------------------------------------------------------------------
`default_nettype none

module split_block_bloom_filter import sbbf_pkg::*; #(
    parameter int MAX_BLOCKS = 1024
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    sbbf_req_if.sink   req,
    sbbf_rsp_if.source rsp,
    sbbf_cfg_if.sink   cfg
);

    sbbf_cmd_t  cmd;
    sbbf_stat_t stat;

    assign cfg.ready = 1'b1;

    sbbf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    sbbf_dp #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .cfg_we      (cfg.valid),
        .cfg_data    (cfg.block_count_log2),
        .req_mode    (req.mode),
        .req_hash    (req.hash_value),
        .req_widx    (req.word_index),
        .req_wdata   (req.word_data),
        .rsp_present (rsp.maybe_present),
        .rsp_word    (rsp.read_word)
    );

    // Write-back only when the response slot is free
    a_commit_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!rsp.valid || rsp.ready))
        else $error("update committed over a pending response");

    // Accepted request is fetched on the next cycle
    a_fetch_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> cmd.rd_block)
        else $error("accepted request not fetched");

    // No intake while the clear sweep runs
    a_no_take_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear_step |-> !req.ready)
        else $error("request accepted during clear sweep");

    // A commit always presents a response
    a_rsp_after_commit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> rsp.valid)
        else $error("commit without response");

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the split-block Bloom filter. A shadow copy of the
// filter store predicts every response. Directed requests cover each mode,
// field extremes and block-count saturation. Random traffic then runs under
// three source/sink stall profiles and several block-count settings.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import sbbf_pkg::*;

    localparam int MAX_BLOCKS  = 1024;
    localparam int STORE_WORDS = MAX_BLOCKS * 8;
    localparam int CYCLE_LIMIT = 200000;
    localparam int TAIL_CYCLES = 20;

    // Salt multipliers, one per word of a block
    localparam logic [31:0] BIT_SALT [8] = '{
        32'h47b6137b, 32'h44974d91, 32'h8824ad5b, 32'ha2b7289d,
        32'h705495c7, 32'h2df1424b, 32'h9efc4947, 32'h5c6bfb31
    };

    typedef struct packed {
        mode_t       mode;
        logic [63:0] hash;
        logic [12:0] widx;
        logic [31:0] wdata;
    } filter_req_t;

    typedef struct packed {
        logic        maybe_present;
        logic [31:0] read_word;
    } filter_rsp_t;

    logic clk;
    logic rst_n;

    sbbf_req_if req_ch ();
    sbbf_rsp_if rsp_ch ();
    sbbf_cfg_if cfg_ch ();

    split_block_bloom_filter #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    // Shadow filter state
    logic [31:0] shadow_words [STORE_WORDS];
    logic [3:0]  shadow_log2;

    filter_rsp_t awaited_rsp [$];
    logic [63:0] inserted_hashes [$];
    int          mismatches;
    int          cycle_count;
    int          src_idle_pct;
    int          snk_idle_pct;

    // Clock
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Response sink stalls
    always @(negedge clk)
    begin
        rsp_ch.ready = ($urandom_range(99) >= snk_idle_pct);
    end

    task automatic report_mismatch(input string msg);
        $display("%0t ns  mismatch: %s", $time, msg);
        mismatches++;
    endtask

    // Block mask after saturation to the store size
    function automatic logic [31:0] active_block_mask();
        int k;
        k = shadow_log2;
        while (k > 0 && (1 << k) > MAX_BLOCKS)
            k--;
        return (32'h1 << k) - 32'h1;
    endfunction

    // One-hot bit chosen in word w by the salted key
    function automatic logic [31:0] salted_bit(input int w, input logic [31:0] key);
        logic [31:0] prod;
        prod = key * BIT_SALT[w];
        return 32'h1 << prod[31:27];
    endfunction

    // Expected response of one request; updates the shadow store
    function automatic filter_rsp_t filter_response(input filter_req_t r);
        filter_rsp_t res;
        int          base;
        logic [31:0] bit_w;
        res  = '0;
        base = int'(r.hash[63:32] & active_block_mask()) * 8;
        case (r.mode)
            MODE_INSERT:
                for (int w = 0; w < 8; w++)
                    shadow_words[base + w] |= salted_bit(w, r.hash[31:0]);
            MODE_QUERY:
            begin
                res.maybe_present = 1'b1;
                for (int w = 0; w < 8; w++)
                begin
                    bit_w = salted_bit(w, r.hash[31:0]);
                    if ((shadow_words[base + w] & bit_w) == 32'h0)
                        res.maybe_present = 1'b0;
                end
            end
            MODE_LOAD:
                if (int'(r.widx) < STORE_WORDS)
                    shadow_words[r.widx] = r.wdata;
            default:
                if (int'(r.widx) < STORE_WORDS)
                    res.read_word = shadow_words[r.widx];
        endcase
        return res;
    endfunction

    // Check responses, then record accepted requests and register writes
    always @(posedge clk)
    begin : scoreboard
        filter_rsp_t oldest;
        filter_req_t r;
        if (!rst_n)
        begin
            // shadow state follows the filter's reset
            for (int i = 0; i < STORE_WORDS; i++)
                shadow_words[i] = 32'h0;
            shadow_log2 = 4'd0;
            mismatches  = 0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (awaited_rsp.size() == 0)
                    report_mismatch("response with no request outstanding");
                else
                begin
                    oldest = awaited_rsp.pop_front();
                    if (rsp_ch.maybe_present !== oldest.maybe_present)
                        report_mismatch($sformatf("maybe_present got %b want %b",
                                        rsp_ch.maybe_present, oldest.maybe_present));
                    if (rsp_ch.read_word !== oldest.read_word)
                        report_mismatch($sformatf("read_word got %h want %h",
                                        rsp_ch.read_word, oldest.read_word));
                end
            end
            if (req_ch.valid && req_ch.ready)
            begin
                r.mode  = mode_t'(req_ch.mode);
                r.hash  = req_ch.hash_value;
                r.widx  = req_ch.word_index;
                r.wdata = req_ch.word_data;
                awaited_rsp.push_back(filter_response(r));
            end
            if (cfg_ch.valid && cfg_ch.ready)
                shadow_log2 = cfg_ch.block_count_log2;
        end
    end

    // Watchdog
    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb_top NOT OK");
        $finish;
    end

    // Issue one request, with random source gaps ahead of it
    task automatic send_request(input mode_t mode, input logic [63:0] hash,
                                input logic [12:0] widx, input logic [31:0] wdata);
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            req_ch.valid = 1'b0;
            @(negedge clk);
        end
        req_ch.valid      = 1'b1;
        req_ch.mode       = mode;
        req_ch.hash_value = hash;
        req_ch.word_index = widx;
        req_ch.word_data  = wdata;
        do
            @(posedge clk);
        while (!req_ch.ready);
    endtask

    // Hold off the source until every response is back
    task automatic wait_all_responses();
        @(negedge clk);
        req_ch.valid = 1'b0;
        while (awaited_rsp.size() != 0)
            @(posedge clk);
    endtask

    // Register write, only with the filter idle
    task automatic set_block_count(input logic [3:0] log2);
        wait_all_responses();
        @(negedge clk);
        cfg_ch.valid            = 1'b1;
        cfg_ch.block_count_log2 = log2;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    // Each mode, field extremes, cleared store
    task automatic test_directed_modes();
        set_block_count(4'd0);
        send_request(MODE_READ,   64'h0, 13'h0,    32'h0);
        send_request(MODE_READ,   '1,    13'h1fff, '1);
        send_request(MODE_QUERY,  64'h0, 13'h0,    32'h0);
        send_request(MODE_INSERT, 64'h0, 13'h1fff, '1);
        send_request(MODE_QUERY,  64'h0, 13'h0,    32'h0);
        send_request(MODE_QUERY,  64'hffff_ffff_0000_0000, 13'h0, 32'h0);
        send_request(MODE_READ,   64'h0, 13'h0,    32'h0);
        send_request(MODE_INSERT, '1,    13'h0,    32'h0);
        send_request(MODE_QUERY,  '1,    13'h1fff, '1);
        send_request(MODE_LOAD,   '1,    13'h1fff, '1);
        send_request(MODE_READ,   64'h0, 13'h1fff, 32'h0);
        send_request(MODE_LOAD,   64'h0, 13'h0,    32'h0);
        send_request(MODE_QUERY,  64'h0, 13'h0,    32'h0);
        send_request(MODE_LOAD,   64'h0, 13'h7,    32'ha5a5_5a5a);
        send_request(MODE_READ,   64'h0, 13'h7,    32'h0);
        send_request(MODE_QUERY,  64'h0123_4567_89ab_cdef, 13'h0, 32'h0);
        send_request(MODE_READ,   64'h0, 13'h1000, 32'h0);
    endtask

    // Oversized block count saturates to the store size; an all-ones block hash hits the last block
    task automatic test_block_count_saturation();
        logic [63:0] h;
        h = 64'hffff_ffff_9e37_79b9;
        set_block_count(4'd15);
        send_request(MODE_INSERT, h, 13'h0, 32'h0);
        for (int w = 0; w < 8; w++)
            send_request(MODE_READ, 64'h0, 13'(STORE_WORDS - 8 + w), 32'h0);
        set_block_count(4'd11);
        send_request(MODE_QUERY, h, 13'h0, 32'h0);
        set_block_count(4'd10);
        send_request(MODE_QUERY, h, 13'h0, 32'h0);
    endtask

    // Random mix: inserts followed by queries of the same keys, raw traffic
    task automatic test_random_traffic(input int n_items, input logic [3:0] log2,
                                       input int src_pct, input int snk_pct);
        int          pick;
        int          span;
        logic [63:0] h;
        logic [12:0] widx;
        logic [31:0] wdata;
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        set_block_count(log2);
        inserted_hashes.delete();
        for (int n = 0; n < n_items; n++)
        begin
            if (n == n_items / 2)
                wait_all_responses();
            span  = (int'(active_block_mask()) + 1) * 8;
            h     = {$urandom, $urandom};
            widx  = ($urandom_range(1) == 0) ? 13'($urandom_range(span - 1))
                                             : 13'($urandom);
            wdata = $urandom;
            if ($urandom_range(9) == 0)
                wdata = ($urandom_range(1) == 0) ? 32'h0 : '1;
            pick = $urandom_range(99);
            if (pick < 35)
            begin
                send_request(MODE_INSERT, h, widx, wdata);
                inserted_hashes.push_back(h);
                if (inserted_hashes.size() > 32)
                    void'(inserted_hashes.pop_front());
            end
            else if (pick < 60)
            begin
                if (inserted_hashes.size() != 0 && $urandom_range(2) != 0)
                    h = inserted_hashes[$urandom_range(inserted_hashes.size() - 1)];
                send_request(MODE_QUERY, h, widx, wdata);
            end
            else if (pick < 75)
                send_request(MODE_LOAD, h, widx, wdata);
            else
                send_request(MODE_READ, h, widx, wdata);
        end
    endtask

    // Test sequence
    initial
    begin
        src_idle_pct            = 30;
        snk_idle_pct            = 61;
        rst_n                   = 1'b0;
        req_ch.valid            = 1'b0;
        req_ch.mode             = MODE_INSERT;
        req_ch.hash_value       = 64'h0;
        req_ch.word_index       = 13'h0;
        req_ch.word_data        = 32'h0;
        cfg_ch.valid            = 1'b0;
        cfg_ch.block_count_log2 = 4'd0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        // clear sweep runs until the filter takes requests
        do
            @(posedge clk);
        while (!req_ch.ready);

        test_directed_modes();
        test_block_count_saturation();
        test_random_traffic(100, 4'd1, 30, 61);
        test_random_traffic(70, 4'd10, 30, 61);
        test_random_traffic(100, 4'd4, 61, 30);
        test_random_traffic(70, 4'd15, 61, 30);
        test_random_traffic(80, 4'($urandom_range(15)), 0, 0);
        test_random_traffic(80, 4'd0, 0, 0);

        // drain, then a short tail for stray responses
        wait_all_responses();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && awaited_rsp.size() == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
